/* src/lfmd_pkg.sv */
// Shared types, constants and helpers for the line-follow motor decider.
package lfmd_pkg;

    localparam int SPEED_BITS = 8;
    localparam int SUM_BITS   = SPEED_BITS + 2;
    localparam logic [SPEED_BITS-1:0] SPEED_MAX = {SPEED_BITS{1'b1}};

    // configuration register indexes
    localparam logic [2:0] REG_BASE_SPEED  = 3'd0;
    localparam logic [2:0] REG_GENTLE_CORR = 3'd1;
    localparam logic [2:0] REG_STRONG_CORR = 3'd2;
    localparam logic [2:0] REG_ROTATE_LIM  = 3'd3;
    localparam logic [2:0] REG_BACKUP_LIM  = 3'd4;
    localparam logic [2:0] REG_REVERSE_LIM = 3'd5;

    // last turn direction codes
    localparam logic [1:0] TURN_NONE  = 2'd0;
    localparam logic [1:0] TURN_LEFT  = 2'd1;
    localparam logic [1:0] TURN_RIGHT = 2'd2;

    // search phase codes
    localparam logic [2:0] PH_LINE     = 3'd0;
    localparam logic [2:0] PH_ROTATE   = 3'd1;
    localparam logic [2:0] PH_BACKUP   = 3'd2;
    localparam logic [2:0] PH_OPPOSITE = 3'd3;
    localparam logic [2:0] PH_LOST     = 3'd4;

    localparam logic [3:0] LOST_MAX = 4'd15;

    // fixed spin and search speeds
    localparam logic [SPEED_BITS-1:0] SPD_90  = SPEED_BITS'(90);
    localparam logic [SPEED_BITS-1:0] SPD_110 = SPEED_BITS'(110);
    localparam logic [SPEED_BITS-1:0] SPD_120 = SPEED_BITS'(120);
    localparam logic [SPEED_BITS-1:0] SPD_125 = SPEED_BITS'(125);
    localparam logic [SPEED_BITS-1:0] SPD_130 = SPEED_BITS'(130);

    typedef struct packed {
        logic [7:0] base_speed;
        logic [7:0] gentle_correction;
        logic [7:0] strong_correction;
        logic [3:0] rotate_limit;
        logic [3:0] backup_limit;
        logic [3:0] reverse_limit;
    } cfg_t;

    typedef struct packed {
        logic [2:0]            search_phase;
        logic [SPEED_BITS-1:0] right_speed;
        logic                  right_reverse;
        logic [SPEED_BITS-1:0] left_speed;
        logic                  left_reverse;
    } motor_cmd_t;

    // clamp a signed speed sum to 0..SPEED_MAX
    function automatic logic [SPEED_BITS-1:0] sat_speed(input logic signed [SUM_BITS-1:0] v);
        logic [SPEED_BITS-1:0] r;
        if (v < 0) begin
            r = '0;
        end else if (v > $signed({2'b00, SPEED_MAX})) begin
            r = SPEED_MAX;
        end else begin
            r = v[SPEED_BITS-1:0];
        end
        return r;
    endfunction

    function automatic logic signed [SUM_BITS-1:0] widen(input logic [7:0] v);
        return $signed(SUM_BITS'(v));
    endfunction

endpackage

/* src/lfmd_decide.sv */
// Decision logic: motor command and next tracking state for one sensor frame.
module lfmd_decide import lfmd_pkg::*; (
    input  logic [4:0] sensor_bits,
    input  logic [3:0] lost_frames,
    input  logic [1:0] last_turn,
    input  cfg_t       cfg,
    output motor_cmd_t cmd,
    output logic [3:0] lost_frames_next,
    output logic [1:0] last_turn_next
);

    logic far_l, near_l, mid, near_r, far_r;
    logic signed [SUM_BITS-1:0] base_s, corr_l_s, corr_r_s;
    logic [3:0] lost_inc;

    assign far_l  = sensor_bits[4];
    assign near_l = sensor_bits[3];
    assign mid    = sensor_bits[2];
    assign near_r = sensor_bits[1];
    assign far_r  = sensor_bits[0];

    assign base_s   = widen(cfg.base_speed);
    assign corr_l_s = widen(far_l ? cfg.strong_correction : cfg.gentle_correction);
    assign corr_r_s = widen(far_r ? cfg.strong_correction : cfg.gentle_correction);
    assign lost_inc = (lost_frames == LOST_MAX) ? LOST_MAX : lost_frames + 4'd1;

    always_comb begin
        cmd              = '0;
        lost_frames_next = lost_frames;
        last_turn_next   = last_turn;
        if (mid) begin
            lost_frames_next = '0;
            if (near_l && !near_r) begin
                last_turn_next  = TURN_LEFT;
                cmd.left_speed  = sat_speed(base_s - corr_l_s);
                cmd.right_speed = sat_speed(base_s + corr_l_s);
            end else if (near_r && !near_l) begin
                last_turn_next  = TURN_RIGHT;
                cmd.left_speed  = sat_speed(base_s + corr_r_s);
                cmd.right_speed = sat_speed(base_s - corr_r_s);
            end else begin
                cmd.left_speed  = sat_speed(base_s);
                cmd.right_speed = sat_speed(base_s);
            end
            cmd.search_phase = PH_LINE;
        end else if (near_l || far_l) begin
            lost_frames_next = '0;
            last_turn_next   = TURN_LEFT;
            cmd.left_reverse = 1'b1;
            cmd.left_speed   = far_l ? sat_speed(base_s) : SPD_110;
            cmd.right_speed  = far_l ? sat_speed(base_s) : SPD_125;
            cmd.search_phase = PH_LINE;
        end else if (near_r || far_r) begin
            lost_frames_next  = '0;
            last_turn_next    = TURN_RIGHT;
            cmd.left_speed    = SPD_130;
            cmd.right_reverse = 1'b1;
            cmd.right_speed   = SPD_110;
            cmd.search_phase  = PH_LINE;
        end else begin
            // line lost: phase follows the saturating lost count
            lost_frames_next = lost_inc;
            if (lost_inc < cfg.rotate_limit) begin
                cmd.search_phase = PH_ROTATE;
                if (last_turn == TURN_RIGHT) begin
                    cmd.left_speed    = SPD_110;
                    cmd.right_reverse = 1'b1;
                    cmd.right_speed   = SPD_130;
                end else begin
                    last_turn_next   = TURN_LEFT;
                    cmd.left_reverse = 1'b1;
                    cmd.left_speed   = SPD_110;
                    cmd.right_speed  = SPD_130;
                end
            end else if (lost_inc < cfg.backup_limit) begin
                cmd.search_phase  = PH_BACKUP;
                cmd.left_reverse  = 1'b1;
                cmd.left_speed    = SPD_120;
                cmd.right_reverse = 1'b1;
                cmd.right_speed   = SPD_120;
            end else if (lost_inc < cfg.reverse_limit) begin
                cmd.search_phase = PH_OPPOSITE;
                if (last_turn == TURN_LEFT) begin
                    cmd.left_speed    = SPD_130;
                    cmd.right_reverse = 1'b1;
                    cmd.right_speed   = SPD_90;
                end else begin
                    cmd.left_reverse = 1'b1;
                    cmd.left_speed   = SPD_90;
                    cmd.right_speed  = SPD_130;
                end
            end else begin
                cmd.search_phase  = PH_LOST;
                cmd.left_reverse  = 1'b1;
                cmd.left_speed    = SPD_120;
                cmd.right_reverse = 1'b1;
                cmd.right_speed   = SPD_120;
            end
        end
    end

endmodule

/* src/line_follow_motor_decider_top.sv */
// Line-follow motor decider: top level with channel registers, state and config.
//
// Usage:
//   s_ channel carries one 5-bit line-sensor frame per request; m_ channel
//   returns one motor command per frame, in order.
//   Configuration registers are written through cfg_we/cfg_index/cfg_data;
//   the user must write them only while no frame is in flight, which the
//   block does not enforce. Writes take effect at once.
// Path: an accepted frame goes through the input register, then the result register.
// Throughput: one frame per cycle, sustained while m_tready stays high; the decision
//   logic between the two registers is a single pass.
// Stall: the input and result registers form a two-deep buffer, so a new
//   frame is still taken while one result waits on m_tready; s_tready drops
//   only when both registers are full.
// Reset (aresetn low, synchronous): both channels empty, registers back to
//   base 220, gentle 20, strong 40, limits 3/6/10, lost count zero and
//   no remembered turn direction.
module line_follow_motor_decider_top import lfmd_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [4:0] sensor_bits
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,    // [0] left_reverse, [8:1] left_speed, [9] right_reverse,
                                    // [17:10] right_speed, [20:18] search_phase
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    cfg_t       cfg_reg, cfg_next;
    logic       in_vld_reg;
    logic [4:0] sensor_reg;
    logic       out_vld_reg;
    motor_cmd_t out_reg;
    logic [3:0] lost_frames_reg, lost_frames_next;
    logic [1:0] last_turn_reg, last_turn_next;
    motor_cmd_t cmd;
    logic       out_free, advance;

    assign out_free = !out_vld_reg || m_tready;
    assign advance  = in_vld_reg && out_free;
    assign s_tready = !in_vld_reg || out_free;
    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {3'b000, out_reg};

    lfmd_decide u_decide (
        .sensor_bits      (sensor_reg),
        .lost_frames      (lost_frames_reg),
        .last_turn        (last_turn_reg),
        .cfg              (cfg_reg),
        .cmd              (cmd),
        .lost_frames_next (lost_frames_next),
        .last_turn_next   (last_turn_next)
    );

    always_comb begin
        cfg_next = cfg_reg;
        case (cfg_index)
            REG_BASE_SPEED:  cfg_next.base_speed        = cfg_data;
            REG_GENTLE_CORR: cfg_next.gentle_correction = cfg_data;
            REG_STRONG_CORR: cfg_next.strong_correction = cfg_data;
            REG_ROTATE_LIM:  cfg_next.rotate_limit      = cfg_data[3:0];
            REG_BACKUP_LIM:  cfg_next.backup_limit      = cfg_data[3:0];
            REG_REVERSE_LIM: cfg_next.reverse_limit     = cfg_data[3:0];
            default:         cfg_next = cfg_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.base_speed        <= 8'd220;
            cfg_reg.gentle_correction <= 8'd20;
            cfg_reg.strong_correction <= 8'd40;
            cfg_reg.rotate_limit      <= 4'd3;
            cfg_reg.backup_limit      <= 4'd6;
            cfg_reg.reverse_limit     <= 4'd10;
            in_vld_reg                <= 1'b0;
            out_vld_reg               <= 1'b0;
            lost_frames_reg           <= '0;
            last_turn_reg             <= TURN_NONE;
        end else begin
            if (cfg_we) begin
                cfg_reg <= cfg_next;
            end
            if (s_tvalid && s_tready) begin
                in_vld_reg <= 1'b1;
            end else if (advance) begin
                in_vld_reg <= 1'b0;
            end
            if (advance) begin
                out_vld_reg     <= 1'b1;
                lost_frames_reg <= lost_frames_next;
                last_turn_reg   <= last_turn_next;
            end else if (m_tready) begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            sensor_reg <= s_tdata[4:0];
        end
        if (advance) begin
            out_reg <= cmd;
        end
    end

`ifndef SYNTHESIS
    a_phase_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (out_reg.search_phase <= PH_LOST))
        else $error("search phase out of range");

    a_turn_code: assert property (@(posedge aclk) disable iff (!aresetn)
        last_turn_reg != 2'd3)
        else $error("invalid last turn code");

    a_lost_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (lost_frames_reg != $past(lost_frames_reg)) |->
            (lost_frames_reg == 4'd0 || lost_frames_reg == $past(lost_frames_reg) + 4'd1))
        else $error("lost count moved other than by clear or increment");

    a_line_clears_lost: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && cmd.search_phase == PH_LINE |=> lost_frames_reg == 4'd0)
        else $error("lost count not cleared on line frame");

    a_backup_reverse: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (out_reg.search_phase == PH_BACKUP || out_reg.search_phase == PH_LOST)
            |-> out_reg.left_reverse && out_reg.right_reverse)
        else $error("backup phase without both motors reversed");
`endif

endmodule
